@@ src/stbs_pkg.sv @@
// Shared types, widths and search-step helpers for the sorted table bound search.
`default_nettype none

package stbs_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   // One halving step per index bit covers any interval of up to TABLE_DEPTH entries
   localparam int STEPS       = IDX_W;

   // Port field widths
   localparam int ACTION_W      = 2;
   localparam int ENTRY_INDEX_W = 10;
   localparam int ENTRY_COUNT_W = 11;
   localparam int POSITION_W    = 10;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_LOWER = 2'd1,
      ACT_UPPER = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Payload of one pipeline slot
   typedef struct packed {
      action_type                     act;
      logic [IDX_W-1:0]               widx;
      logic signed [VALUE_WIDTH-1:0]  val;
      logic [IDX_W-1:0]               lo;
      logic [IDX_W-1:0]               hi;
   } slot_type;

   // Probe index of the current interval: floor for lower, ceiling for upper
   function automatic logic [IDX_W-1:0] probe_index(slot_type s);
      logic [IDX_W:0] sum;
      sum = {1'b0, s.lo} + {1'b0, s.hi} + {{IDX_W{1'b0}}, (s.act == ACT_UPPER)};
      return sum[IDX_W:1];
   endfunction

   // Narrow the interval after the probed entry came back
   function automatic slot_type narrow(slot_type s, logic [IDX_W-1:0] mid,
                                       logic signed [VALUE_WIDTH-1:0] rd);
      slot_type r;
      r = s;
      if (s.lo < s.hi) begin
         case (s.act)
            ACT_LOWER: begin
               if (s.val > rd) r.lo = mid + 1'b1;
               else            r.hi = mid;
            end
            ACT_UPPER: begin
               if (s.val < rd) r.hi = mid - 1'b1;
               else            r.lo = mid;
            end
            default: r = s;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/stbs_stage.sv @@
// One search step: a private copy of the table, its registered read and the next slot.
`default_nettype none

module stbs_stage (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   advance,
   input  wire logic                                   in_valid,
   input  wire stbs_pkg::slot_type                     in_slot,
   output logic                                        out_valid,
   output stbs_pkg::slot_type                          out_slot,
   output logic [stbs_pkg::IDX_W-1:0]                  out_mid,
   output logic signed [stbs_pkg::VALUE_WIDTH-1:0]     out_rdata
);

   logic signed [stbs_pkg::VALUE_WIDTH-1:0] entries_ff [stbs_pkg::TABLE_DEPTH];
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] rdata_ff;
   logic [stbs_pkg::IDX_W-1:0]              mid_in;
   logic [stbs_pkg::IDX_W-1:0]              mid_ff;
   logic                                    wr_en;
   logic                                    valid_ff;
   stbs_pkg::slot_type                      slot_ff;

   // Probe address, and table write when a write word passes this step
   assign mid_in = stbs_pkg::probe_index(in_slot);
   assign wr_en  = advance && in_valid && (in_slot.act == stbs_pkg::ACT_WRITE);

   // Table copy: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[in_slot.widx] <= in_slot.val;
      end
      if (advance) begin
         rdata_ff <= entries_ff[mid_in];
      end
   end

   // Slot valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Slot payload
   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= in_slot;
         mid_ff  <= mid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_slot  = slot_ff;
   assign out_mid   = mid_ff;
   assign out_rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/sorted_table_bound_search_top.sv @@
// Sorted table bound search: pipelined lower/upper bound lookup over a written table.
//
// Request channel (req_valid / req_stall) carries one word per accepted edge:
// action 0 writes req_value at req_entry_index, 1 asks for the first index whose
// entry is >= req_value, 2 for the last index whose entry is <= req_value.
// Action 3 and writes beyond the table are dropped. Only queries give a
// response word on rsp_valid / rsp_stall with rsp_position.
// csr_wr_en / csr_wr_data set the number of entries in use (clamped to the table
// depth); change it only while no word is in flight. An empty table answers 0.
// A query accepted at one edge enters the entry slot at that edge, then passes one slot
// per halving step and then one output register. Throughput is one word per cycle while
// the response is not stalled; each step keeps its own table copy so every step reads
// once per cycle, and a write updates each copy as it passes, keeping words in order.
// Reset clears all valid bits and the entry count; table contents are undefined
// until written. While the response is stalled the whole pipeline holds and
// req_stall is high; nothing is dropped or repeated.
`default_nettype none

module sorted_table_bound_search_top (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic [stbs_pkg::ACTION_W-1:0]               req_action,
   input  wire logic [stbs_pkg::ENTRY_INDEX_W-1:0]          req_entry_index,
   input  wire logic signed [stbs_pkg::VALUE_WIDTH-1:0]     req_value,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic [stbs_pkg::POSITION_W-1:0]                  rsp_position,
   input  wire logic                                        csr_wr_en,
   input  wire logic [stbs_pkg::ENTRY_COUNT_W-1:0]          csr_wr_data
);

   localparam int Steps = stbs_pkg::STEPS;

   logic [stbs_pkg::ENTRY_COUNT_W-1:0]      entry_count_ff;
   logic                                    advance;
   logic [31:0]                             used_count;
   logic                                    in_range;
   stbs_pkg::action_type                    req_act;
   stbs_pkg::slot_type                      s0_slot_in;
   stbs_pkg::slot_type                      s0_slot_ff;
   logic                                    s0_valid_ff;
   logic                                    rsp_valid_in;
   logic                                    rsp_valid_ff;
   logic [stbs_pkg::POSITION_W-1:0]         rsp_position_ff;

   logic                                    valid_q [Steps+1];
   stbs_pkg::slot_type                      slot_q  [Steps+1];
   stbs_pkg::slot_type                      res_q   [Steps+1];
   logic [stbs_pkg::IDX_W-1:0]              mid_q   [Steps];
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] rd_q    [Steps];

   // Entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   // Global hold: everything moves when the output register can take a word
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Entry slot: decode action, set up the initial interval
   always_comb begin
      used_count = 32'(entry_count_ff);
      if (used_count > 32'(stbs_pkg::TABLE_DEPTH)) begin
         used_count = 32'(stbs_pkg::TABLE_DEPTH);
      end
      in_range = 32'(req_entry_index) < 32'(stbs_pkg::TABLE_DEPTH);
      req_act  = stbs_pkg::action_type'(req_action);
      if (req_act == stbs_pkg::ACT_WRITE && !in_range) begin
         req_act = stbs_pkg::ACT_NONE;
      end
      s0_slot_in.act  = req_act;
      s0_slot_in.widx = (stbs_pkg::IDX_W)'(req_entry_index);
      s0_slot_in.val  = req_value;
      s0_slot_in.lo   = '0;
      if (used_count == 32'd0) begin
         s0_slot_in.hi = '0;
      end else begin
         s0_slot_in.hi = (stbs_pkg::IDX_W)'(used_count - 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_slot_ff <= s0_slot_in;
      end
   end

   assign valid_q[0] = s0_valid_ff;
   assign slot_q[0]  = s0_slot_ff;
   assign res_q[0]   = s0_slot_ff;

   // Halving steps
   for (genvar k = 0; k < Steps; k++) begin : g_step
      stbs_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_q[k]),
         .in_slot   (res_q[k]),
         .out_valid (valid_q[k+1]),
         .out_slot  (slot_q[k+1]),
         .out_mid   (mid_q[k]),
         .out_rdata (rd_q[k])
      );
      assign res_q[k+1] = stbs_pkg::narrow(slot_q[k+1], mid_q[k], rd_q[k]);
   end

   // Output register: queries only
   assign rsp_valid_in = valid_q[Steps] &&
                         (res_q[Steps].act == stbs_pkg::ACT_LOWER ||
                          res_q[Steps].act == stbs_pkg::ACT_UPPER);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_position_ff <= (stbs_pkg::POSITION_W)'(res_q[Steps].lo);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;

endmodule

`default_nettype wire

@@ src/stbs_checker.sv @@
// Port-level checks for the sorted table bound search, bound to the top level.
`default_nettype none

module stbs_checker (
   input wire logic                                     clock,
   input wire logic                                     reset,
   input wire logic                                     req_valid,
   input wire logic                                     req_stall,
   input wire logic                                     rsp_valid,
   input wire logic                                     rsp_stall,
   input wire logic [stbs_pkg::POSITION_W-1:0]          rsp_position
);

   // No response word right after reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position))
      else $error("stalled response changed");

   // Blocked output backs up into the request side
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response blocked");

   // Empty output never stalls requests
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // A valid response carries a known position
   a_rsp_known : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_position))
      else $error("response position unknown");

endmodule

bind sorted_table_bound_search_top stbs_checker u_stbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_position (rsp_position)
);

`default_nettype wire

@@ tb/sv/sorted_table_bound_search_top_test.sv @@
// Self-checking testbench for the sorted table bound search: directed table, random phases.
module sorted_table_bound_search_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 14;    // pipeline latency plus margin
   localparam int HOLD_CYCLES   = 80;    // long receiver hold-off, fills the pipeline
   localparam int QUIET_LIMIT   = 5000;  // cycles with no word moving before giving up
   localparam int WORD_TARGET   = 1820;  // directed rows plus about 1800 random words
   localparam int DIRECTED_ROWS = 23;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   // One row of the directed table; a CSR row carries the entry count in val
   typedef struct packed {
      row_kind_type                            kind;
      stbs_pkg::action_type                    act;
      logic [stbs_pkg::ENTRY_INDEX_W-1:0]      idx;
      logic signed [stbs_pkg::VALUE_WIDTH-1:0] val;
      logic                                    pinned;
      logic [stbs_pkg::POSITION_W-1:0]         pos;
   } plan_row_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   stbs_pkg::action_type                    req_action = stbs_pkg::ACT_WRITE;
   logic [stbs_pkg::ENTRY_INDEX_W-1:0]      req_entry_index = '0;
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic [stbs_pkg::POSITION_W-1:0]         rsp_position;
   logic                                    csr_wr_en = 1'b0;
   logic [stbs_pkg::ENTRY_COUNT_W-1:0]      csr_wr_data = '0;

   // typed-in expectation, travels alongside the request word
   logic                                    req_pinned = 1'b0;
   logic [stbs_pkg::POSITION_W-1:0]         req_pinned_pos = '0;

   // predictor state
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] shadow_entries [stbs_pkg::TABLE_DEPTH];
   logic [stbs_pkg::ENTRY_COUNT_W-1:0]      shadow_count = '0;
   logic [stbs_pkg::POSITION_W-1:0]         expected_positions [$];

   // stimulus bookkeeping
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] planned_values [stbs_pkg::TABLE_DEPTH];
   bit                                      entry_written [stbs_pkg::TABLE_DEPTH];
   int unsigned                             mismatches = 0;
   int unsigned                             words_sent = 0;
   int unsigned                             quiet_cycles = 0;
   int unsigned                             send_idle_pct = 38;
   int unsigned                             recv_idle_pct = 82;
   logic                                    hold_request = 1'b0;
   bit                                      hold_done = 1'b0;

   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      // empty table answers 0
      '{ROW_WORD, stbs_pkg::ACT_LOWER, 10'd0,    32'sd0,        1'b1, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_UPPER, 10'd1023, 32'sh80000000, 1'b1, 10'd0},
      // unused action, no response
      '{ROW_WORD, stbs_pkg::ACT_NONE,  10'd1023, 32'shFFFFFFFF, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_WRITE, 10'd0,    -32'sd100,     1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_WRITE, 10'd1,    -32'sd5,       1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_WRITE, 10'd2,    32'sd7,        1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_WRITE, 10'd3,    32'sh7FFFFFFF, 1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_WRITE, 10'd1023, 32'sh80000000, 1'b0, 10'd0},
      '{ROW_CSR,  stbs_pkg::ACT_NONE,  10'd0,    32'sd4,        1'b0, 10'd0},
      // key below everything: lower hits 0, upper finds none and gives 0
      '{ROW_WORD, stbs_pkg::ACT_LOWER, 10'd0,    32'sh80000000, 1'b1, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_UPPER, 10'd0,    32'sh80000000, 1'b1, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_LOWER, 10'd0,    32'sh7FFFFFFF, 1'b1, 10'd3},
      '{ROW_WORD, stbs_pkg::ACT_UPPER, 10'd0,    32'sh7FFFFFFF, 1'b1, 10'd3},
      '{ROW_WORD, stbs_pkg::ACT_LOWER, 10'd0,    32'sd0,        1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_UPPER, 10'd0,    32'sd0,        1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_LOWER, 10'd512,  -32'sd5,       1'b1, 10'd1},
      '{ROW_WORD, stbs_pkg::ACT_UPPER, 10'd511,  -32'sd5,       1'b1, 10'd1},
      // every entry below the key: lower falls back to the last entry in use
      '{ROW_CSR,  stbs_pkg::ACT_NONE,  10'd0,    32'sd3,        1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_LOWER, 10'd0,    32'sh7FFFFFFF, 1'b1, 10'd2},
      '{ROW_WORD, stbs_pkg::ACT_UPPER, 10'd0,    32'sh7FFFFFFF, 1'b1, 10'd2},
      '{ROW_CSR,  stbs_pkg::ACT_NONE,  10'd0,    32'sd1,        1'b0, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_LOWER, 10'd0,    32'sh80000000, 1'b1, 10'd0},
      '{ROW_WORD, stbs_pkg::ACT_UPPER, 10'd0,    32'sh7FFFFFFF, 1'b1, 10'd0}
   };

   sorted_table_bound_search_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #5ns clock = ~clock;

   // Binary search over the shadow table, lower or upper bound
   function automatic logic [stbs_pkg::POSITION_W-1:0] bound_position(
         stbs_pkg::action_type act, logic signed [stbs_pkg::VALUE_WIDTH-1:0] key);
      int unsigned n, lo, hi, mid;
      n  = (shadow_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : shadow_count;
      lo = 0;
      hi = (n == 0) ? 0 : n - 1;
      while (lo < hi) begin
         if (act == stbs_pkg::ACT_LOWER) begin
            mid = (lo + hi) / 2;
            if (key > shadow_entries[mid]) lo = mid + 1;
            else                           hi = mid;
         end else begin
            mid = (lo + hi + 1) / 2;
            if (key < shadow_entries[mid]) hi = mid - 1;
            else                           lo = mid;
         end
      end
      return lo[stbs_pkg::POSITION_W-1:0];
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns mismatch: %s, position %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Scoreboard: predict on accepted request words, check response words
   always @(posedge clock) begin : scoreboard
      logic [stbs_pkg::POSITION_W-1:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            case (req_action) inside
               stbs_pkg::ACT_WRITE: shadow_entries[req_entry_index] = req_value;
               stbs_pkg::ACT_LOWER, stbs_pkg::ACT_UPPER: begin
                  want = req_pinned ? req_pinned_pos : bound_position(req_action, req_value);
                  expected_positions.push_back(want);
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               report_mismatch("response word with nothing expected", int'(rsp_position), -1);
            end else begin
               want = expected_positions.pop_front();
               if (rsp_position !== want)
                  report_mismatch("position", int'(rsp_position), int'(want));
            end
         end
      end
   end

   // Watchdog: ends the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else                                                        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("FAIL sorted_table_bound_search_top");
         $finish;
      end
   end

   // Response side: random stall, or one long hold-off on request
   initial begin : receiver
      int k;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Offer one request word and return at the edge that accepts it
   task automatic send_word(stbs_pkg::action_type act,
                            logic [stbs_pkg::ENTRY_INDEX_W-1:0] idx,
                            logic signed [stbs_pkg::VALUE_WIDTH-1:0] val,
                            logic pinned, logic [stbs_pkg::POSITION_W-1:0] pos);
      // idling pattern moves on with the run
      if (words_sent >= 1220) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end else if (words_sent >= 620) begin
         send_idle_pct = 82;
         recv_idle_pct = 38;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_entry_index <= idx;
      req_value       <= val;
      req_pinned      <= pinned;
      req_pinned_pos  <= pos;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (act != stbs_pkg::ACT_NONE) words_sent++;
      if (act == stbs_pkg::ACT_WRITE) begin
         entry_written[idx]  = 1'b1;
         planned_values[idx] = val;
      end
   endtask

   // Stop sending, wait for every response, then let in-flight writes retire
   task automatic drain_block();
      int unsigned settled;
      settled = 0;
      req_valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      while (settled < SETTLE_CYCLES) begin
         @(posedge clock);
         if (!rsp_stall) settled++;
      end
   endtask

   task automatic write_entry_count(logic [stbs_pkg::ENTRY_COUNT_W-1:0] count);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      shadow_count = count;
   endtask

   // One phase: refill the searched range if needed, set the count, then mixed traffic
   task automatic run_phase(logic [stbs_pkg::ENTRY_COUNT_W-1:0] count, int unsigned queries);
      int unsigned                             used, r, j;
      bit                                      rebuild;
      int                                      fresh [$];
      logic signed [stbs_pkg::VALUE_WIDTH-1:0] key, data;
      logic [stbs_pkg::ENTRY_INDEX_W-1:0]      spot;
      used    = (count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : count;
      rebuild = (used <= 100);
      // never search an entry that was not written
      for (j = 0; j < used; j++)
         if (!entry_written[j]) rebuild = 1'b1;
      if (rebuild) begin
         r = $urandom_range(0, 7);
         // narrow value range gives runs of duplicates
         for (j = 0; j < used; j++)
            fresh.push_back((r < 2) ? int'($urandom_range(0, 15)) - 8 : int'($urandom));
         // mostly sorted tables, now and then an unsorted one
         if (r != 7) fresh.sort();
         for (j = 0; j < used; j++)
            send_word(stbs_pkg::ACT_WRITE, j[stbs_pkg::ENTRY_INDEX_W-1:0], fresh[j],
                      1'b0, '0);
      end
      write_entry_count(count);
      // once, with the sender at full rate, hold the receiver off for a long stretch
      if (!hold_done && send_idle_pct == 0) begin
         hold_done = 1'b1;
         hold_request <= 1'b1;
      end
      for (j = 0; j < queries; j++) begin
         r = $urandom_range(0, 99);
         if (used != 0 && r < 50)
            key = planned_values[$urandom_range(0, used - 1)] + (int'($urandom_range(0, 2)) - 1);
         else if (r < 55) key = 32'sh80000000;
         else if (r < 60) key = 32'sh7FFFFFFF;
         else             key = $urandom;
         spot = (stbs_pkg::ENTRY_INDEX_W)'($urandom);
         r    = $urandom_range(0, 99);
         if (r < 44) begin
            send_word(stbs_pkg::ACT_LOWER, spot, key, 1'b0, '0);
         end else if (r < 88) begin
            send_word(stbs_pkg::ACT_UPPER, spot, key, 1'b0, '0);
         end else if (r < 94) begin
            // stray write, may land inside the searched range
            data = $urandom;
            send_word(stbs_pkg::ACT_WRITE, spot, data, 1'b0, '0);
         end else begin
            send_word(stbs_pkg::ACT_NONE, spot, key, 1'b0, '0);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned row, r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_plan[row].kind == ROW_CSR) begin
            write_entry_count(directed_plan[row].val[stbs_pkg::ENTRY_COUNT_W-1:0]);
         end else begin
            send_word(directed_plan[row].act, directed_plan[row].idx, directed_plan[row].val,
                      directed_plan[row].pinned, directed_plan[row].pos);
         end
      end

      // tiny tables, empty table, full table, counts past the table depth
      run_phase(11'd1, 30);
      run_phase(11'd2, 30);
      run_phase(11'd0, 20);
      run_phase(11'd1024, 60);
      run_phase(11'd2047, 50);
      run_phase(11'd1023, 40);
      while (words_sent < WORD_TARGET) begin
         r = $urandom_range(0, 9);
         case (r)
            0: run_phase((stbs_pkg::ENTRY_COUNT_W)'($urandom_range(1025, 2046)),
                         $urandom_range(20, 60));
            1: run_phase(11'd1024, $urandom_range(20, 60));
            2: run_phase((stbs_pkg::ENTRY_COUNT_W)'($urandom_range(101, 1023)),
                         $urandom_range(20, 60));
            default: run_phase((stbs_pkg::ENTRY_COUNT_W)'($urandom_range(1, 100)),
                               $urandom_range(20, 60));
         endcase
      end

      drain_block();
      if (mismatches == 0 && expected_positions.size() == 0) begin
         $display("PASS sorted_table_bound_search_top");
      end else begin
         $display("FAIL sorted_table_bound_search_top");
      end
      $finish;
   end

endmodule
